@@ rtl/mrc_pkg.sv @@
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types and constants of the multi-channel rotator controller.
// ----------------------------------------------------------------------------
package mrc_pkg;

	localparam int NUM_CHANNELS = 5;
	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	localparam logic [15:0] INTERVAL_RESET = 16'd20;
	localparam logic [9:0] ANGLE_MAX = 10'd1023;

	localparam logic [2:0] MUX_MAP [5] = '{3'd0, 3'd2, 3'd4, 3'd1, 3'd3};

	typedef enum logic [2:0] {
		OP_SET_ANGLE = 3'd0,
		OP_ROTATE_CW = 3'd1,
		OP_ROTATE_CCW = 3'd2,
		OP_STOP = 3'd3,
		OP_SAMPLE = 3'd4,
		OP_TICK = 3'd5,
		OP_QUERY = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		MOT_STOP = 2'd0,
		MOT_CW = 2'd1,
		MOT_CCW = 2'd2
	} motion_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic report;
	} ctrl_cmd_t;

endpackage

@@ rtl/mrc_ctrl.sv @@
// ----------------------------------------------------------------------------
// mrc_ctrl
// Sequencer: load an item, execute its update, then report the result.
// ----------------------------------------------------------------------------
module mrc_ctrl
	import mrc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output logic      done,
	output ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_REPORT
	} state_t;

	state_t state_q;
	logic busy_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
						busy_q <= 1'b1;
					end
				end
				ST_EXEC: begin
					state_q <= ST_REPORT;
				end
				ST_REPORT: begin
					state_q <= ST_IDLE;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign cmd.load = start && (state_q == ST_IDLE);
	assign cmd.exec = (state_q == ST_EXEC);
	assign cmd.report = (state_q == ST_REPORT);

endmodule

@@ rtl/mrc_datapath.sv @@
// ----------------------------------------------------------------------------
// mrc_datapath
// Channel state, tick counter, service step, relay drive and result register.
// ----------------------------------------------------------------------------
module mrc_datapath
	import mrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_cmd_t   cmd,
	input  logic [2:0]  operation,
	input  logic [7:0]  channel,
	input  logic [15:0] angle,
	input  logic [9:0]  sample,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	output logic        accepted,
	output logic [2:0]  channel_out,
	output logic [9:0]  current_out,
	output logic [9:0]  target_out,
	output logic        target_active,
	output logic [1:0]  direction_out,
	output logic [5:0]  relay_group_c,
	output logic [5:0]  relay_group_a,
	output logic [2:0]  mux_select,
	output logic        start_conversion
);

	function automatic logic [5:0] relay_c(input logic [5:0] r, input logic [1:0] ch,
			input motion_t m);
		logic [5:0] cw;
		logic [5:0] ccw;
		cw = 6'b010000 >> {ch, 1'b0};
		ccw = 6'b100000 >> {ch, 1'b0};
		unique case (m)
			MOT_CCW: relay_c = (r & ~cw) | ccw;
			MOT_CW: relay_c = (r & ~ccw) | cw;
			default: relay_c = r & ~(cw | ccw);
		endcase
	endfunction

	function automatic logic [5:0] relay_a(input logic [5:0] r, input logic upper,
			input motion_t m);
		logic [5:0] b0;
		logic [5:0] b1;
		logic [5:0] b2;
		b0 = upper ? 6'b001000 : 6'b000001;
		b1 = b0 << 1;
		b2 = b0 << 2;
		unique case (m)
			MOT_CCW: relay_a = (r | b0 | b2) & ~b1;
			MOT_CW: relay_a = (r & ~b0) | b1 | b2;
			default: relay_a = r & ~(b0 | b1 | b2);
		endcase
	endfunction

	logic [9:0] heading_q [NUM_CHANNELS];
	logic [9:0] target_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] tvalid_q;
	motion_t motion_q [NUM_CHANNELS];
	logic [IDX_W-1:0] sel_q;
	logic [15:0] tick_q;
	logic [15:0] interval_q;
	logic [5:0] relc_q;
	logic [5:0] rela_q;

	op_t op_q;
	logic [15:0] angle_q;
	logic [9:0] sample_q;
	logic [IDX_W-1:0] idx_q;
	logic ok_q;
	logic svc_q;

	logic [9:0] res_cur_q;
	logic [9:0] res_tgt_q;
	logic res_tv_q;
	motion_t res_mot_q;
	logic res_acc_q;
	logic [2:0] res_chan_q;
	logic res_start_q;

	logic is_cmd;
	logic ch_ok;
	logic [IDX_W-1:0] idx_d;

	logic [9:0] cur;
	logic [9:0] tgt;
	logic tv;
	motion_t mot;
	logic [9:0] angle_c;
	logic [2:0] idx3;

	logic [9:0] hd_n;
	logic [9:0] tg_n;
	logic tv_n;
	motion_t mo_n;
	logic [15:0] tick_inc;
	logic [15:0] tick_n;
	logic svc;
	logic [IDX_W-1:0] sel_n;
	logic [5:0] relc_n;
	logic [5:0] rela_n;

	assign is_cmd = (operation <= 3'(OP_STOP)) || (operation == 3'(OP_QUERY));
	assign ch_ok = channel < 8'(NUM_CHANNELS);

	always_comb begin
		idx_d = '0;
		if (is_cmd && ch_ok) begin
			idx_d = channel[IDX_W-1:0];
		end else if (!is_cmd) begin
			idx_d = sel_q;
		end
	end

	assign cur = heading_q[idx_q];
	assign tgt = target_q[idx_q];
	assign tv = tvalid_q[idx_q];
	assign mot = motion_q[idx_q];
	assign idx3 = 3'(idx_q);
	assign angle_c = (angle_q > 16'(ANGLE_MAX)) ? ANGLE_MAX : angle_q[9:0];
	assign tick_inc = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : tick_q;

	always_comb begin
		hd_n = cur;
		tg_n = tgt;
		tv_n = tv;
		mo_n = mot;
		tick_n = tick_q;
		svc = 1'b0;
		sel_n = sel_q;
		relc_n = relc_q;
		rela_n = rela_q;
		unique case (op_q)
			OP_SET_ANGLE: begin
				if (angle_c > cur) begin
					tg_n = angle_c;
					tv_n = 1'b1;
					mo_n = MOT_CW;
				end else if (angle_c < cur) begin
					tg_n = angle_c;
					tv_n = 1'b1;
					mo_n = MOT_CCW;
				end else begin
					tv_n = 1'b0;
					mo_n = MOT_STOP;
				end
			end
			OP_ROTATE_CW: begin
				mo_n = MOT_CW;
				tv_n = 1'b0;
			end
			OP_ROTATE_CCW: begin
				mo_n = MOT_CCW;
				tv_n = 1'b0;
			end
			OP_STOP: begin
				mo_n = MOT_STOP;
				tv_n = 1'b0;
			end
			OP_SAMPLE: begin
				hd_n = sample_q;
			end
			OP_TICK: begin
				tick_n = tick_inc;
				if (tick_inc >= interval_q) begin
					tick_n = '0;
					svc = 1'b1;
					if (tv && ((mot == MOT_CCW && cur <= tgt) ||
							(mot == MOT_CW && cur >= tgt))) begin
						tv_n = 1'b0;
						mo_n = MOT_STOP;
					end
					if (idx3 <= 3'd2) begin
						relc_n = relay_c(relc_q, idx3[1:0], mo_n);
					end else begin
						rela_n = relay_a(rela_q, idx3 == 3'd4, mo_n);
					end
					sel_n = (sel_q == IDX_W'(NUM_CHANNELS - 1)) ? '0 : sel_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				heading_q[i] <= '0;
				target_q[i] <= '0;
				motion_q[i] <= MOT_STOP;
			end
			tvalid_q <= '0;
			sel_q <= '0;
			tick_q <= '0;
			interval_q <= INTERVAL_RESET;
			relc_q <= '0;
			rela_q <= '0;
			ok_q <= 1'b0;
			svc_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				interval_q <= cfg_data;
			end
			if (cmd.exec && ok_q) begin
				heading_q[idx_q] <= hd_n;
				target_q[idx_q] <= tg_n;
				tvalid_q[idx_q] <= tv_n;
				motion_q[idx_q] <= mo_n;
				tick_q <= tick_n;
				sel_q <= sel_n;
				relc_q <= relc_n;
				rela_q <= rela_n;
			end
			if (cmd.exec) begin
				svc_q <= svc && ok_q;
			end
			if (cmd.load) begin
				ok_q <= is_cmd ? ch_ok
					: (operation == 3'(OP_SAMPLE)) || (operation == 3'(OP_TICK));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op_t'(operation);
			angle_q <= angle;
			sample_q <= sample;
			idx_q <= idx_d;
		end
		if (cmd.report) begin
			res_acc_q <= ok_q;
			res_chan_q <= ok_q ? idx3 : '0;
			res_cur_q <= ok_q ? cur : '0;
			res_tgt_q <= ok_q ? (tv ? tgt : cur) : '0;
			res_tv_q <= ok_q && tv;
			res_mot_q <= ok_q ? mot : MOT_STOP;
			res_start_q <= svc_q;
		end
	end

	assign accepted = res_acc_q;
	assign channel_out = res_chan_q;
	assign current_out = res_cur_q;
	assign target_out = res_tgt_q;
	assign target_active = res_tv_q;
	assign direction_out = res_mot_q;
	assign relay_group_c = relc_q;
	assign relay_group_a = rela_q;
	assign mux_select = MUX_MAP[3'(sel_q)];
	assign start_conversion = res_start_q;

endmodule

@@ rtl/multi_channel_rotator_controller_top.sv @@
// ----------------------------------------------------------------------------
// multi_channel_rotator_controller_top
// Five-channel rotator controller: commands, heading samples and service ticks.
//
// Channel   Handshake             Payload
// command   start / busy          operation, channel, angle, sample
// result    done (one-cycle)      accepted .. start_conversion
// config    cfg_valid / cfg_ready cfg_data (service interval)
//
// An item passes through load, execute and report; the result shows in the
// cycle after the report step, with busy already low.
// The next item is taken while that result is on the ports.
// Reset clears all channel state; the service interval returns to 20.
// Results cannot be held off, so nothing stalls on the output side.
// ----------------------------------------------------------------------------
module multi_channel_rotator_controller_top
	import mrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [7:0]  channel,
	input  logic [15:0] angle,
	input  logic [9:0]  sample,
	output logic        done,
	output logic        accepted,
	output logic [2:0]  channel_out,
	output logic [9:0]  current_out,
	output logic [9:0]  target_out,
	output logic        target_active,
	output logic [1:0]  direction_out,
	output logic [5:0]  relay_group_c,
	output logic [5:0]  relay_group_a,
	output logic [2:0]  mux_select,
	output logic        start_conversion,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	ctrl_cmd_t cmd;

	assign cfg_ready = 1'b1;

	mrc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	mrc_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.operation        (operation),
		.channel          (channel),
		.angle            (angle),
		.sample           (sample),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_data         (cfg_data),
		.accepted         (accepted),
		.channel_out      (channel_out),
		.current_out      (current_out),
		.target_out       (target_out),
		.target_active    (target_active),
		.direction_out    (direction_out),
		.relay_group_c    (relay_group_c),
		.relay_group_a    (relay_group_a),
		.mux_select       (mux_select),
		.start_conversion (start_conversion)
	);

endmodule

@@ rtl/mrc_checker.sv @@
// ----------------------------------------------------------------------------
// mrc_checker
// Port-level checks of the rotator controller, bound to the top level.
// ----------------------------------------------------------------------------
module mrc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       accepted,
	input logic [2:0] channel_out,
	input logic [9:0] current_out,
	input logic [1:0] direction_out,
	input logic       start_conversion
);

	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("result missing three cycles after item accept");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !accepted |-> channel_out == 3'd0 && current_out == 10'd0
			&& direction_out == 2'd0)
		else $error("rejected item reports nonzero channel fields");

	a_conv_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		start_conversion && done |-> accepted)
		else $error("conversion start on a rejected item");

endmodule

bind multi_channel_rotator_controller_top mrc_checker u_mrc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.accepted         (accepted),
	.channel_out      (channel_out),
	.current_out      (current_out),
	.direction_out    (direction_out),
	.start_conversion (start_conversion)
);
